[rtl/dqft_pkg.sv]
// shared types, constants and sine table builder for the dq frame transform
`default_nettype none

package dqft_pkg;

    typedef enum logic [1:0] {
        OP_CLARKE,
        OP_PARK,
        OP_INV_PARK,
        OP_INV_CLARKE
    } opcode_t;

    localparam int SINE_TABLE_DEPTH = 256;
    localparam int ROM_TW = $clog2(SINE_TABLE_DEPTH);
    localparam int ROM_IW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int ROM_PROD_W = 15 + ROM_IW;

    localparam int SAMPLE_W = 16;
    localparam int ANGLE_W = 16;
    localparam int IN_TDATA_W = 64;
    localparam int IN_TUSER_W = 2;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 1;

    localparam int OPA_W = 18;
    localparam int OPB_W = 21;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int ACC_W = PROD_W + 1;

    localparam logic signed [OPB_W-1:0] Q_ONE_THIRD_Q20 = 21'sd349525;
    localparam logic signed [OPB_W-1:0] Q_INV_SQRT3_Q20 = 21'sd605396;
    localparam logic signed [OPB_W-1:0] Q_SQRT3_HALF_Q20 = 21'sd908093;
    localparam logic [15:0] QUARTER_TURN = 16'd16384;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint Q30_ONE = 64'sd1073741824;

    // quarter-wave sine entry, q30 taylor series to x^15, truncating steps
    function automatic logic [14:0] sine_entry(int i);
        longint x;
        longint x2;
        longint term;
        longint acc;
        longint r;
        x = HALF_PI_Q30 * longint'(i) / SINE_TABLE_DEPTH;
        x2 = x * x / Q30_ONE;
        term = x;
        acc = x;
        term = -(term * x2 / Q30_ONE);
        term = term / 6;
        acc = acc + term;
        term = -(term * x2 / Q30_ONE);
        term = term / 20;
        acc = acc + term;
        term = -(term * x2 / Q30_ONE);
        term = term / 42;
        acc = acc + term;
        term = -(term * x2 / Q30_ONE);
        term = term / 72;
        acc = acc + term;
        term = -(term * x2 / Q30_ONE);
        term = term / 110;
        acc = acc + term;
        term = -(term * x2 / Q30_ONE);
        term = term / 156;
        acc = acc + term;
        term = -(term * x2 / Q30_ONE);
        term = term / 210;
        acc = acc + term;
        if (acc < 0) begin
            acc = 0;
        end
        r = (acc * 32767 + 64'sd536870912) >>> 30;
        if (r > 32767) begin
            r = 32767;
        end
        return r[14:0];
    endfunction

endpackage

`default_nettype wire

[rtl/abc_dq_frame_transform_top.sv]
// clarke, park and inverse transforms in a five stage pipeline
// a request passes the capture, table read, product, sum and output stages in order
// throughput: one request per cycle unless stalled, one multiplier stage of four products
// each stage holds its item under backpressure and refills as soon as the next one moves
// reset: aresetn synchronous active low clears all stage valid bits
// the sine table is constant logic, so no clearing pass follows reset
`default_nettype none

module abc_dq_frame_transform_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // x0 [15:0], x1 [31:16], x2 [47:32], angle [63:48]
    input  wire logic [dqft_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode [1:0]
    input  wire logic [dqft_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // y0 [15:0], y1 [31:16], y2 [47:32]
    output logic [dqft_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // clipped [0]
    output logic [dqft_pkg::OUT_TUSER_W-1:0]      m_axis_tuser
);
    import dqft_pkg::*;

    localparam logic [14:0] ROM_LAST = sine_entry(SINE_TABLE_DEPTH);
    localparam logic signed [ACC_W-1:0] HALF_Q20 = ACC_W'(524288);
    localparam logic signed [ACC_W-1:0] HALF_Q15 = ACC_W'(16384);

    logic [14:0] sine_rom [SINE_TABLE_DEPTH];

    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
        assign sine_rom[g] = sine_entry(g);
    end

    function automatic logic [ROM_IW-1:0] rom_index(logic [15:0] ang);
        logic [14:0] p;
        logic [ROM_PROD_W-1:0] prod;
        p = ang[14] ? (15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
        prod = ROM_PROD_W'(p) * ROM_PROD_W'(SINE_TABLE_DEPTH);
        return prod[14 +: ROM_IW];
    endfunction

    function automatic logic [SAMPLE_W:0] sat16(logic signed [ACC_W-1:0] v);
        logic [SAMPLE_W:0] res;
        if (v > ACC_W'(32767)) begin
            res = {1'b1, 16'h7fff};
        end else if (v < -ACC_W'(32768)) begin
            res = {1'b1, 16'h8000};
        end else begin
            res = {1'b0, v[15:0]};
        end
        return res;
    endfunction

    // stage enables
    logic en1, en2, en3, en4, en5;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    assign en5 = !v5_reg || m_axis_tready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_axis_tready = en1;

    // stage 1: capture and table addresses
    opcode_t                  op1_reg;
    logic signed [15:0]       x0_1_reg, x1_1_reg, x2_1_reg;
    logic [ROM_IW-1:0]        sin_idx_reg, cos_idx_reg;
    logic                     sin_neg_reg, cos_neg_reg;
    logic [15:0]              cos_ang_next;

    assign cos_ang_next = s_axis_tdata[63:48] + QUARTER_TURN;

    // stage 2: table read and clarke differences
    opcode_t                  op2_reg;
    logic signed [15:0]       x0_2_reg, x1_2_reg;
    logic signed [OPA_W-1:0]  u0_reg, u0_next;
    logic signed [16:0]       u1_reg, u1_next;
    logic signed [15:0]       sin_reg, sin_next, cos_reg, cos_next;
    logic [14:0]              sin_mag, cos_mag;

    always_comb begin
        sin_mag = (sin_idx_reg == ROM_IW'(SINE_TABLE_DEPTH)) ? ROM_LAST
                : sine_rom[sin_idx_reg[ROM_TW-1:0]];
        cos_mag = (cos_idx_reg == ROM_IW'(SINE_TABLE_DEPTH)) ? ROM_LAST
                : sine_rom[cos_idx_reg[ROM_TW-1:0]];
        sin_next = sin_neg_reg ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
        cos_next = cos_neg_reg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
        u0_next = (OPA_W'(x0_1_reg) <<< 1) - OPA_W'(x1_1_reg) - OPA_W'(x2_1_reg);
        u1_next = 17'(x1_1_reg) - 17'(x2_1_reg);
    end

    // stage 3: products
    opcode_t                   op3_reg;
    logic signed [15:0]        x0_3_reg;
    logic signed [PROD_W-1:0]  p0_reg, p0_next, p1_reg, p1_next;
    logic signed [31:0]        p2_reg, p2_next, p3_reg, p3_next;
    logic signed [OPA_W-1:0]   a0, a1;
    logic signed [OPB_W-1:0]   b0, b1;

    always_comb begin
        a0 = (op2_reg == OP_CLARKE) ? u0_reg : OPA_W'(x0_2_reg);
        b0 = (op2_reg == OP_CLARKE) ? Q_ONE_THIRD_Q20 : OPB_W'(cos_reg);
        a1 = (op2_reg == OP_CLARKE) ? OPA_W'(u1_reg) : OPA_W'(x1_2_reg);
        if (op2_reg == OP_CLARKE) begin
            b1 = Q_INV_SQRT3_Q20;
        end else if (op2_reg == OP_INV_CLARKE) begin
            b1 = Q_SQRT3_HALF_Q20;
        end else begin
            b1 = OPB_W'(sin_reg);
        end
        p0_next = PROD_W'(a0) * PROD_W'(b0);
        p1_next = PROD_W'(a1) * PROD_W'(b1);
        p2_next = 32'(x1_2_reg) * 32'(cos_reg);
        p3_next = 32'(x0_2_reg) * 32'(sin_reg);
    end

    // stage 4: sums with rounding offset
    opcode_t                   op4_reg;
    logic signed [ACC_W-1:0]   r0_reg, r0_next, r1_reg, r1_next, r2_reg, r2_next;
    logic signed [ACC_W-1:0]   e0, e1, e2, e3, ax;

    always_comb begin
        e0 = ACC_W'(p0_reg);
        e1 = ACC_W'(p1_reg);
        e2 = ACC_W'(p2_reg);
        e3 = ACC_W'(p3_reg);
        ax = -(ACC_W'(x0_3_reg) <<< 19);
        case (op3_reg)
            OP_CLARKE: begin
                r0_next = e0 + HALF_Q20;
                r1_next = e1 + HALF_Q20;
                r2_next = HALF_Q20;
            end
            OP_PARK: begin
                r0_next = e0 + e1 + HALF_Q15;
                r1_next = e2 - e3 + HALF_Q15;
                r2_next = HALF_Q15;
            end
            OP_INV_PARK: begin
                r0_next = e0 - e1 + HALF_Q15;
                r1_next = e2 + e3 + HALF_Q15;
                r2_next = HALF_Q15;
            end
            OP_INV_CLARKE: begin
                r0_next = (ACC_W'(x0_3_reg) <<< 20) + HALF_Q20;
                r1_next = ax + e1 + HALF_Q20;
                r2_next = ax - e1 + HALF_Q20;
            end
            default: begin
                r0_next = '0;
                r1_next = '0;
                r2_next = '0;
            end
        endcase
    end

    // stage 5: shift, saturate, output register
    logic [15:0]        y0_reg, y1_reg, y2_reg;
    logic               clip_reg, clip_next;
    logic [SAMPLE_W:0]  s0, s1, s2;
    logic signed [ACC_W-1:0] h0, h1, h2;

    always_comb begin
        if (op4_reg == OP_PARK || op4_reg == OP_INV_PARK) begin
            h0 = r0_reg >>> 15;
            h1 = r1_reg >>> 15;
            h2 = r2_reg >>> 15;
        end else begin
            h0 = r0_reg >>> 20;
            h1 = r1_reg >>> 20;
            h2 = r2_reg >>> 20;
        end
        s0 = sat16(h0);
        s1 = sat16(h1);
        s2 = sat16(h2);
        clip_next = s0[SAMPLE_W] | s1[SAMPLE_W] | s2[SAMPLE_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= s_axis_tvalid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
            if (en4) begin
                v4_reg <= v3_reg;
            end
            if (en5) begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            op1_reg     <= opcode_t'(s_axis_tuser);
            x0_1_reg    <= s_axis_tdata[15:0];
            x1_1_reg    <= s_axis_tdata[31:16];
            x2_1_reg    <= s_axis_tdata[47:32];
            sin_idx_reg <= rom_index(s_axis_tdata[63:48]);
            sin_neg_reg <= s_axis_tdata[63];
            cos_idx_reg <= rom_index(cos_ang_next);
            cos_neg_reg <= cos_ang_next[15];
        end
        if (en2) begin
            op2_reg  <= op1_reg;
            x0_2_reg <= x0_1_reg;
            x1_2_reg <= x1_1_reg;
            u0_reg   <= u0_next;
            u1_reg   <= u1_next;
            sin_reg  <= sin_next;
            cos_reg  <= cos_next;
        end
        if (en3) begin
            op3_reg  <= op2_reg;
            x0_3_reg <= x0_2_reg;
            p0_reg   <= p0_next;
            p1_reg   <= p1_next;
            p2_reg   <= p2_next;
            p3_reg   <= p3_next;
        end
        if (en4) begin
            op4_reg <= op3_reg;
            r0_reg  <= r0_next;
            r1_reg  <= r1_next;
            r2_reg  <= r2_next;
        end
        if (en5) begin
            y0_reg   <= s0[15:0];
            y1_reg   <= s1[15:0];
            y2_reg   <= s2[15:0];
            clip_reg <= clip_next;
        end
    end

    assign m_axis_tvalid = v5_reg;
    assign m_axis_tdata  = {y2_reg, y1_reg, y0_reg};
    assign m_axis_tuser  = clip_reg;

    // an accepted request lands in the first stage
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> v1_reg)
        else $error("accepted request missing from first stage");

    // a stalled first stage keeps its item
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && !en2 |=> v1_reg)
        else $error("first stage item lost under stall");

    // a moving sum stage item reaches the output
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg && en5 |=> m_axis_tvalid)
        else $error("item lost between sum stage and output");

    // the clip flag only comes with a saturated field
    a_clip_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |->
            (y0_reg == 16'h7fff || y0_reg == 16'h8000 ||
             y1_reg == 16'h7fff || y1_reg == 16'h8000 ||
             y2_reg == 16'h7fff || y2_reg == 16'h8000))
        else $error("clip flag without a saturated field");

endmodule

`default_nettype wire
